// File: src/scsa_pkg.sv
package scsa_pkg;

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_FREE    = 2'd1,
    FUNC_COLLECT = 2'd2,
    FUNC_NOP     = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] req_size;
    logic [3:0] free_chunk;
    logic [1:0] free_block;
  } req_t;

  typedef struct packed {
    logic [3:0] got_chunk;
    logic [1:0] got_block;
    logic [1:0] size_class;
    logic [1:0] status;
    logic [4:0] freed_count;
  } rsp_t;

  // full free map per class
  function automatic logic [3:0] class_full(input logic [1:0] cls);
    case (cls)
      2'd0:    class_full = 4'hF;
      2'd1:    class_full = 4'h3;
      default: class_full = 4'h1;
    endcase
  endfunction

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture request, compute class
    logic walk_init; // set cursor to head of class list
    logic walk_step; // test cursor chunk, advance
    logic grab_new;  // take a pool chunk and link it
    logic free_do;   // apply a free
    logic col_init;  // start collect of class col
    logic col_step;  // visit one chunk of class col
    logic col_fin;   // close the kept ring
    logic [1:0] col_cls;
    logic finish;    // build response
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_alloc;
    logic is_free;
    logic is_collect;
    logic too_large;
    logic present;   // class list present
    logic hit;       // cursor chunk has a free block
    logic wrapped;   // next cursor returns to head
    logic walk_last; // step count exhausted
  } sts_t;

endpackage

// File: src/scsa_datapath.sv
module scsa_datapath #(
  parameter int NUM_CHUNKS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  scsa_pkg::req_t  req_i,
  input  scsa_pkg::cmd_t  cmd_i,
  output scsa_pkg::sts_t  sts_o,
  output scsa_pkg::rsp_t  rsp_o
);

  localparam int IW = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int CW = $clog2(NUM_CHUNKS + 1);

  // chunk state
  logic [NUM_CHUNKS-1:0] taken_q;
  logic [1:0]            cls_q  [NUM_CHUNKS];
  logic [3:0]            fmap_q [NUM_CHUNKS];
  logic [IW-1:0]         next_q [NUM_CHUNKS];
  logic [IW-1:0]         head_q [3];
  logic [2:0]            pres_q;

  // request and walk registers
  scsa_pkg::req_t req_q;
  logic [1:0]    cls_r_q;
  logic [IW-1:0] cur_q;
  logic [CW-1:0] cnt_q;
  logic [4:0]    freed_q;
  logic [IW-1:0] last_q;     // last kept chunk in collect
  logic [IW-1:0] first_q;    // first kept chunk
  logic          kept_q;
  logic [IW-1:0] tail_q;     // chunk before head for insert
  scsa_pkg::rsp_t rsp_q;

  logic [3:0] m_cur;
  logic [1:0] lb;
  logic [IW-1:0] free_idx;
  logic          pool_full;
  logic          fc_ok;
  logic [IW-1:0] fc;
  logic [3:0]    fbit;
  logic          free_bad;
  logic [1:0]    ccls;

  assign ccls  = cmd_i.col_cls;
  assign m_cur = fmap_q[cur_q] & scsa_pkg::class_full(cls_r_q);
  always_comb begin
    if (m_cur[0])      lb = 2'd0;
    else if (m_cur[1]) lb = 2'd1;
    else if (m_cur[2]) lb = 2'd2;
    else               lb = 2'd3;
  end

  // lowest free pool chunk
  always_comb begin
    free_idx  = '0;
    pool_full = 1'b1;
    for (int i = NUM_CHUNKS - 1; i >= 0; i--) begin
      if (!taken_q[i]) begin
        free_idx  = IW'(i);
        pool_full = 1'b0;
      end
    end
  end

  // free check
  assign fc_ok = ({4'd0, req_q.free_chunk} < 8'(NUM_CHUNKS));
  assign fc    = IW'(req_q.free_chunk);
  assign fbit  = 4'd1 << req_q.free_block;
  assign free_bad = !fc_ok || !taken_q[fc] ||
                    ((scsa_pkg::class_full(cls_q[fc]) & fbit) == 4'd0) ||
                    ((fmap_q[fc] & fbit) != 4'd0);

  // status to controller
  always_comb begin
    sts_o.is_alloc   = (req_q.func == scsa_pkg::FUNC_ALLOC);
    sts_o.is_free    = (req_q.func == scsa_pkg::FUNC_FREE);
    sts_o.is_collect = (req_q.func == scsa_pkg::FUNC_COLLECT);
    sts_o.too_large  = (req_q.req_size > 8'd32);
    sts_o.present    = cmd_i.col_init ? pres_q[ccls] : pres_q[cls_r_q];
    sts_o.hit        = (m_cur != 4'd0);
    sts_o.wrapped    = (next_q[cur_q] == head_q[cmd_i.col_step ? ccls : cls_r_q]);
    sts_o.walk_last  = (cnt_q == CW'(NUM_CHUNKS - 1));
  end

  // state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= '0;
      pres_q  <= '0;
    end else begin
      if (cmd_i.grab_new && !pool_full) begin
        taken_q[free_idx] <= 1'b1;
        pres_q[cls_r_q]   <= 1'b1;
      end
      if (cmd_i.col_step &&
          (fmap_q[cur_q] & scsa_pkg::class_full(ccls)) == scsa_pkg::class_full(ccls)) begin
        taken_q[cur_q] <= 1'b0;
      end
      if (cmd_i.col_fin && !kept_q) pres_q[ccls] <= 1'b0;
    end
  end

  // payload registers and link rings
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
      if (req_i.req_size <= 8'd8)       cls_r_q <= 2'd0;
      else if (req_i.req_size <= 8'd16) cls_r_q <= 2'd1;
      else                              cls_r_q <= 2'd2;
      freed_q <= '0;
    end
    if (cmd_i.walk_init) begin
      cur_q  <= head_q[cls_r_q];
      tail_q <= head_q[cls_r_q];
      cnt_q  <= '0;
    end
    if (cmd_i.walk_step) begin
      if (sts_o.hit) fmap_q[cur_q] <= fmap_q[cur_q] & ~(4'd1 << lb);
      tail_q <= cur_q;
      cur_q  <= next_q[cur_q];
      cnt_q  <= cnt_q + 1'b1;
    end
    if (cmd_i.grab_new && !pool_full) begin
      cls_q[free_idx]  <= cls_r_q;
      fmap_q[free_idx] <= scsa_pkg::class_full(cls_r_q) & 4'hE;
      head_q[cls_r_q]  <= free_idx;
      if (pres_q[cls_r_q]) begin
        next_q[free_idx] <= head_q[cls_r_q];
        next_q[tail_q]   <= free_idx;
      end else begin
        next_q[free_idx] <= free_idx;
      end
    end
    if (cmd_i.free_do && !free_bad) fmap_q[fc] <= fmap_q[fc] | fbit;
    if (cmd_i.col_init) begin
      cur_q  <= head_q[ccls];
      cnt_q  <= '0;
      kept_q <= 1'b0;
    end
    if (cmd_i.col_step) begin
      if ((fmap_q[cur_q] & scsa_pkg::class_full(ccls)) == scsa_pkg::class_full(ccls)) begin
        freed_q <= freed_q + 5'd1;
      end else begin
        if (kept_q) next_q[last_q] <= cur_q;
        else        first_q <= cur_q;
        last_q <= cur_q;
        kept_q <= 1'b1;
      end
      cur_q <= next_q[cur_q];
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.col_fin && kept_q) begin
      next_q[last_q] <= first_q;
      head_q[ccls]   <= first_q;
    end
    if (cmd_i.finish) begin
      unique case (req_q.func)
        scsa_pkg::FUNC_ALLOC: begin
          rsp_q <= '{got_chunk: 4'd0, got_block: 2'd0,
                     size_class: sts_o.too_large ? 2'd0 : cls_r_q,
                     status: sts_o.too_large ? scsa_pkg::ST_TOO_LARGE : scsa_pkg::ST_OK,
                     freed_count: 5'd0};
        end
        scsa_pkg::FUNC_FREE: begin
          rsp_q <= '{got_chunk: 4'd0, got_block: 2'd0, size_class: 2'd0,
                     status: free_bad ? scsa_pkg::ST_BAD_FREE : scsa_pkg::ST_OK,
                     freed_count: 5'd0};
        end
        scsa_pkg::FUNC_COLLECT: begin
          rsp_q <= '{got_chunk: 4'd0, got_block: 2'd0, size_class: 2'd0,
                     status: scsa_pkg::ST_OK, freed_count: freed_q};
        end
        default: rsp_q <= '0;
      endcase
    end
    // alloc results written at the hit or grab
    if (cmd_i.walk_step && sts_o.hit) begin
      rsp_q <= '{got_chunk: 4'(cur_q), got_block: lb, size_class: cls_r_q,
                 status: scsa_pkg::ST_OK, freed_count: 5'd0};
    end
    if (cmd_i.grab_new) begin
      rsp_q <= '{got_chunk: pool_full ? 4'd0 : 4'(free_idx), got_block: 2'd0,
                 size_class: cls_r_q,
                 status: pool_full ? scsa_pkg::ST_EXHAUSTED : scsa_pkg::ST_OK,
                 freed_count: 5'd0};
    end
  end

  assign rsp_o = rsp_q;

endmodule

// File: src/scsa_ctrl.sv
module scsa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_stall_o,
  output logic            rsp_valid_o,
  input  logic            rsp_stall_i,
  input  scsa_pkg::sts_t  sts_i,
  output scsa_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_WALK, S_GRAB, S_CINIT, S_CSTEP, S_CFIN, S_DONE
  } state_e;

  state_e state_q;
  logic [1:0] ccls_q;
  logic       walk_end_q; // walk step found no free block

  assign req_stall_o = (state_q != S_IDLE) || rsp_valid_o;

  // command decode from state
  always_comb begin
    cmd_o = '0;
    cmd_o.col_cls = ccls_q;
    unique case (state_q)
      S_IDLE:   cmd_o.load = req_valid_i && !req_stall_o;
      S_DECODE: begin
        if (sts_i.is_alloc && !sts_i.too_large && sts_i.present) cmd_o.walk_init = 1'b1;
        if (sts_i.is_free) begin
          cmd_o.free_do = 1'b1;
          cmd_o.finish  = 1'b1;
        end
        if (!sts_i.is_alloc && !sts_i.is_free && !sts_i.is_collect) cmd_o.finish = 1'b1;
        if (sts_i.is_alloc && sts_i.too_large) cmd_o.finish = 1'b1;
      end
      S_WALK:   cmd_o.walk_step = 1'b1;
      S_GRAB:   cmd_o.grab_new = 1'b1;
      S_CINIT:  cmd_o.col_init = 1'b1;
      S_CSTEP:  cmd_o.col_step = 1'b1;
      S_CFIN:   begin
        cmd_o.col_fin = 1'b1;
        if (ccls_q == 2'd2) cmd_o.finish = 1'b1;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ccls_q      <= 2'd0;
      rsp_valid_o <= 1'b0;
      walk_end_q  <= 1'b0;
    end else begin
      if (rsp_valid_o && !rsp_stall_i) rsp_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: if (cmd_o.load) state_q <= S_DECODE;
        S_DECODE: begin
          if (sts_i.is_alloc && !sts_i.too_large) begin
            state_q <= sts_i.present ? S_WALK : S_GRAB;
          end else if (sts_i.is_collect) begin
            ccls_q  <= 2'd0;
            state_q <= S_CINIT;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_WALK: begin
          if (sts_i.hit) state_q <= S_DONE;
          else if (sts_i.wrapped || sts_i.walk_last) state_q <= S_GRAB;
        end
        S_GRAB: state_q <= S_DONE;
        S_CINIT: state_q <= sts_i.present ? S_CSTEP : S_CFIN;
        S_CSTEP: if (sts_i.wrapped || sts_i.walk_last) state_q <= S_CFIN;
        S_CFIN: begin
          if (ccls_q == 2'd2) state_q <= S_DONE;
          else begin
            ccls_q  <= ccls_q + 2'd1;
            state_q <= S_CINIT;
          end
        end
        S_DONE: begin
          rsp_valid_o <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      walk_end_q <= (state_q == S_WALK) && !sts_i.hit;
    end
  end

  // checks
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> req_stall_o) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> rsp_valid_o) else $error("result lost");
  a_grab_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GRAB) |=> (state_q == S_DONE)) else $error("grab sequence");
  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_end_q |-> (state_q == S_WALK || state_q == S_GRAB)) else $error("walk exit");

endmodule

// File: src/size_class_slab_allocator.sv
// Slab allocator with 8, 16 and 32 byte size classes over a chunk pool.
// Request channel: req_valid_i / req_stall_o carrying req_i (func, size,
// free chunk and block). Response channel: rsp_valid_o / rsp_stall_i
// carrying rsp_o; every request gives exactly one response.
// One request is handled at a time. From accept to response valid:
//   free, bad size or unused func: decode, then done
//   alloc: decode, a walk step per chunk visited in the class ring
//     (at most NUM_CHUNKS), a grab if a new pool chunk is taken, then done
//   collect: decode, per class an init, a step per linked chunk and a fin, done
// The ring walk visits one chunk per cycle.
// A new request is taken the cycle after the previous response has been
// taken.
// While the receiver stalls, the response holds steady and stays valid.
// Reset empties the pool and all class lists; no clearing pass is needed.
module size_class_slab_allocator #(
  parameter int NUM_CHUNKS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_stall_o,
  input  scsa_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_stall_i,
  output scsa_pkg::rsp_t rsp_o
);

  scsa_pkg::cmd_t cmd;
  scsa_pkg::sts_t sts;

  scsa_ctrl u_ctrl (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .rsp_valid_o, .rsp_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  scsa_datapath #(.NUM_CHUNKS(NUM_CHUNKS)) u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .sts_o(sts), .rsp_o
  );

endmodule

// File: verif/size_class_slab_allocator_tb.sv
`timescale 1ns / 1ps

module size_class_slab_allocator_tb;

  localparam int NCH = 16;
  localparam int LIMIT_CYCLES = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_stall_o;
  scsa_pkg::req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_stall_i = 1'b0;
  scsa_pkg::rsp_t rsp_o;

  // stall sampled at the last rising edge, i.e. whether the offer was taken
  logic req_stall_o_q = 1'b1;

  size_class_slab_allocator #(.NUM_CHUNKS(NCH)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_valid_i(req_valid_i), .req_stall_o(req_stall_o), .req_i(req_i),
    .rsp_valid_o(rsp_valid_o), .rsp_stall_i(rsp_stall_i), .rsp_o(rsp_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // allocator shadow state
  bit          sh_taken [NCH];
  logic [1:0]  sh_class [NCH];
  logic [3:0]  sh_map   [NCH];
  logic [3:0]  sh_next  [NCH];
  logic [3:0]  sh_prev  [NCH];
  logic [3:0]  sh_head  [3];
  bit          sh_live  [3];

  scsa_pkg::req_t pending_reqs[$];
  scsa_pkg::rsp_t expected_rsps[$];
  int   mismatches = 0;
  int   sent = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_off = 1'b0;
  longint cycles = 0;

  function automatic logic [3:0] full_map(input logic [1:0] cls);
    return (cls == 2'd0) ? 4'hF : (cls == 2'd1) ? 4'h3 : 4'h1;
  endfunction

  function automatic logic [1:0] lowest_free(input logic [3:0] m);
    if (m[0]) return 2'd0;
    if (m[1]) return 2'd1;
    if (m[2]) return 2'd2;
    return 2'd3;
  endfunction

  // compute the response for one request and update the shadow
  function automatic scsa_pkg::rsp_t allocator_predict(input scsa_pkg::req_t r);
    scsa_pkg::rsp_t o;
    logic [1:0] cls;
    logic [3:0] m;
    logic [3:0] ring [NCH];
    int c, h, p, n, k, freed;
    o = '0;
    case (scsa_pkg::func_e'(r.func))
      scsa_pkg::FUNC_ALLOC: begin
        if (r.req_size > 8'd32) begin
          o.status = scsa_pkg::ST_TOO_LARGE;
          return o;
        end
        cls = (r.req_size <= 8) ? 2'd0 : (r.req_size <= 16) ? 2'd1 : 2'd2;
        o.size_class = cls;
        if (sh_live[cls]) begin
          c = sh_head[cls];
          for (int i = 0; i < NCH; i++) begin
            m = sh_map[c] & full_map(cls);
            if (m != 0) begin
              o.got_block = lowest_free(m);
              sh_map[c] = m & ~(4'd1 << o.got_block);
              o.got_chunk = 4'(c);
              return o;
            end
            c = sh_next[c];
            if (c == sh_head[cls]) break;
          end
        end
        for (c = 0; c < NCH; c++) if (!sh_taken[c]) break;
        if (c >= NCH) begin
          o.status = scsa_pkg::ST_EXHAUSTED;
          return o;
        end
        sh_taken[c] = 1'b1;
        sh_class[c] = cls;
        sh_map[c] = full_map(cls) & 4'hE;
        if (sh_live[cls]) begin
          h = sh_head[cls];
          p = sh_prev[h];
          sh_next[c] = 4'(h);
          sh_prev[c] = 4'(p);
          sh_next[p] = 4'(c);
          sh_prev[h] = 4'(c);
        end else begin
          sh_next[c] = 4'(c);
          sh_prev[c] = 4'(c);
        end
        sh_head[cls] = 4'(c);
        sh_live[cls] = 1'b1;
        o.got_chunk = 4'(c);
      end
      scsa_pkg::FUNC_FREE: begin
        c = r.free_chunk;
        if (!sh_taken[c] || r.free_block > (full_map(sh_class[c]) == 4'hF ? 3 :
            full_map(sh_class[c]) == 4'h3 ? 1 : 0) || sh_map[c][r.free_block]) begin
          o.status = scsa_pkg::ST_BAD_FREE;
          return o;
        end
        sh_map[c][r.free_block] = 1'b1;
      end
      scsa_pkg::FUNC_COLLECT: begin
        freed = 0;
        for (int cl = 0; cl < 3; cl++) begin
          if (!sh_live[cl]) continue;
          n = 0;
          c = sh_head[cl];
          while (n < NCH) begin
            ring[n] = 4'(c);
            n++;
            c = sh_next[c];
            if (c == sh_head[cl]) break;
          end
          k = 0;
          for (int i = 0; i < n; i++) begin
            if ((sh_map[ring[i]] & full_map(2'(cl))) == full_map(2'(cl))) begin
              sh_taken[ring[i]] = 1'b0;
              freed++;
            end else begin
              ring[k] = ring[i];
              k++;
            end
          end
          if (k == 0) begin
            sh_live[cl] = 1'b0;
            continue;
          end
          for (int i = 0; i < k; i++) begin
            sh_next[ring[i]] = ring[(i + 1) % k];
            sh_prev[ring[(i + 1) % k]] = ring[i];
          end
          sh_head[cl] = ring[0];
        end
        o.freed_count = 5'(freed);
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic scsa_pkg::req_t mk_req(input scsa_pkg::func_e f, input int sz,
                                            input int ch, input int bl);
    scsa_pkg::req_t r;
    r.func = f;
    r.req_size = 8'(sz);
    r.free_chunk = 4'(ch);
    r.free_block = 2'(bl);
    return r;
  endfunction

  // random request weighted towards useful traffic
  function automatic scsa_pkg::req_t rand_req();
    scsa_pkg::req_t r;
    int sel;
    r = scsa_pkg::req_t'(16'($urandom));
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      r.func = scsa_pkg::FUNC_ALLOC;
      r.req_size = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) :
                   8'($urandom_range(0, 32));
    end else if (sel < 88) begin
      r.func = scsa_pkg::FUNC_FREE;
    end else if (sel < 97) begin
      r.func = scsa_pkg::FUNC_COLLECT;
    end else begin
      r.func = scsa_pkg::FUNC_NOP;
    end
    return r;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_valid_i && !req_stall_o_q) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req_i <= pending_reqs.pop_front();
          req_valid_i <= 1'b1;
        end else begin
          req_valid_i <= 1'b0;
        end
      end else if (!req_valid_i) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req_i <= pending_reqs.pop_front();
          req_valid_i <= 1'b1;
        end
      end
      rsp_stall_i <= hold_off || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    scsa_pkg::rsp_t exp_r;
    req_stall_o_q <= req_stall_o;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
        $display("Simulation FAILED");
        $finish;
      end
      if (req_valid_i && !req_stall_o) begin
        expected_rsps.push_back(allocator_predict(req_i));
        sent <= sent + 1;
      end
      if (rsp_valid_o && !rsp_stall_i) begin
        if (expected_rsps.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected response %p", rsp_o);
        end else begin
          exp_r = expected_rsps.pop_front();
          if (rsp_o !== exp_r) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("mismatch: expected %p got %p", exp_r, rsp_o);
          end
        end
      end
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (sent > 300);
    @(negedge clk_i);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    @(negedge clk_i);
    hold_off = 1'b0;
  end

  task automatic run_phase(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) pending_reqs.push_back(rand_req());
    wait (pending_reqs.size() == 0);
  endtask

  initial begin
    for (int i = 0; i < NCH; i++) begin
      sh_taken[i] = 1'b0;
      sh_class[i] = '0;
      sh_map[i] = '0;
      sh_next[i] = '0;
      sh_prev[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      sh_head[i] = '0;
      sh_live[i] = 1'b0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: special cases and field extremes
    pending_reqs.push_back(mk_req(scsa_pkg::FUNC_COLLECT, 0, 0, 0));
    pending_reqs.push_back(mk_req(scsa_pkg::FUNC_FREE, 0, 15, 3));
    pending_reqs.push_back(mk_req(scsa_pkg::FUNC_ALLOC, 0, 0, 0));
    pending_reqs.push_back(mk_req(scsa_pkg::FUNC_ALLOC, 8, 0, 0));
    pending_reqs.push_back(mk_req(scsa_pkg::FUNC_ALLOC, 9, 0, 0));
    pending_reqs.push_back(mk_req(scsa_pkg::FUNC_ALLOC, 16, 0, 0));
    pending_reqs.push_back(mk_req(scsa_pkg::FUNC_ALLOC, 17, 0, 0));
    pending_reqs.push_back(mk_req(scsa_pkg::FUNC_ALLOC, 32, 0, 0));
    pending_reqs.push_back(mk_req(scsa_pkg::FUNC_ALLOC, 33, 0, 0));
    pending_reqs.push_back(mk_req(scsa_pkg::FUNC_ALLOC, 255, 15, 3));
    pending_reqs.push_back(mk_req(scsa_pkg::FUNC_FREE, 0, 0, 0));
    pending_reqs.push_back(mk_req(scsa_pkg::FUNC_FREE, 0, 0, 0));
    pending_reqs.push_back(mk_req(scsa_pkg::FUNC_FREE, 0, 1, 2));
    pending_reqs.push_back(mk_req(scsa_pkg::FUNC_FREE, 0, 2, 3));
    pending_reqs.push_back(mk_req(scsa_pkg::FUNC_NOP, 255, 15, 3));
    for (int i = 0; i < 7; i++) pending_reqs.push_back(mk_req(scsa_pkg::FUNC_ALLOC, 32, 0, 0));
    pending_reqs.push_back(mk_req(scsa_pkg::FUNC_ALLOC, 20, 0, 0));
    pending_reqs.push_back(mk_req(scsa_pkg::FUNC_COLLECT, 0, 0, 0));
    wait (pending_reqs.size() == 0);

    // random traffic across idle and stall profiles
    run_phase(330, 0, 0);
    run_phase(330, 55, 0);
    run_phase(330, 0, 55);
    run_phase(340, 15, 15);

    // drain
    wait (expected_rsps.size() == 0 && !req_valid_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/scsa_pkg.sv
src/scsa_datapath.sv
src/scsa_ctrl.sv
src/size_class_slab_allocator.sv
verif/size_class_slab_allocator_tb.sv
